FILE: design/ppnf_pkg.sv
// Shared types, constants and arithmetic helpers for the particle pool block.
package ppnf_pkg;

    // Operation codes of an input item.
    localparam logic OP_SPAWN = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_LIFE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE = 2'd2;

    localparam logic [15:0] INIT_LIFE_RST = 16'd19661;
    localparam logic [11:0] FADE_RATE_RST = 12'd640;
    localparam logic [15:0] VEL_SCALE_RST = 16'd6554;

    localparam logic [8:0] Q_ONE       = 9'd256;
    localparam logic [8:0] BRIGHT_BASE = 9'd128;
    localparam logic [6:0] RAND_MAX    = 7'd99;
    // ceil(2^22 / 100), exact for r * 256 below 2^15
    localparam logic [15:0] DIV100_MUL = 16'd41944;
    localparam int SLOT_W = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SPAWN,
        ST_TICK
    } state_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [15:0]        life;
        logic [8:0]         bright;
        logic [8:0]         alpha;
    } slot_entry_t;

    localparam slot_entry_t ENTRY_RST = '{
        px: 32'sd0, py: 32'sd0, pz: 32'sd0,
        vx: 32'sd0, vy: 32'sd0, vz: 32'sd0,
        life: 16'd0, bright: Q_ONE, alpha: Q_ONE
    };

    // Clamp a 33-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // 128 + floor(min(r, 99) * 256 / 100), by reciprocal multiply.
    function automatic logic [8:0] bright_of(input logic [6:0] r);
        logic [6:0]  rc;
        logic [22:0] prod;
        rc   = (r > RAND_MAX) ? RAND_MAX : r;
        prod = 23'(rc) * 23'(DIV100_MUL);
        return BRIGHT_BASE + 9'(prod[22:14]);
    endfunction

endpackage

FILE: design/ppnf_pool_mem.sv
// Particle state memory: one entry per slot, registered read, valid bits for reset.
module ppnf_pool_mem #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output ppnf_pkg::slot_entry_t rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  ppnf_pkg::slot_entry_t wr_data
);

    ppnf_pkg::slot_entry_t mem [DEPTH];
    ppnf_pkg::slot_entry_t rd_q_reg;
    logic [DEPTH-1:0]      vld_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // An entry never written reads as its reset contents.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : ppnf_pkg::ENTRY_RST;

    a_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en && wr_en |-> rd_addr != wr_addr)
        else $error("read and write hit the same slot in one cycle");

    a_write_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> vld_reg[$past(wr_addr)])
        else $error("written slot not marked valid");

endmodule

FILE: design/ppnf_slot_calc.sv
// Next contents of a slot for a tick and for a spawn.
module ppnf_slot_calc (
    input  ppnf_pkg::slot_entry_t cur,
    input  logic [15:0]           step_dt,
    input  logic [11:0]           fall,
    input  logic signed [31:0]    emit_x,
    input  logic signed [31:0]    emit_y,
    input  logic signed [31:0]    emit_z,
    input  logic signed [31:0]    emit_vx,
    input  logic signed [31:0]    emit_vy,
    input  logic signed [31:0]    emit_vz,
    input  logic signed [31:0]    shift_x,
    input  logic signed [31:0]    shift_y,
    input  logic signed [31:0]    shift_z,
    input  logic [6:0]            color_random,
    input  logic [15:0]           initial_life,
    input  logic [15:0]           velocity_scale,
    output ppnf_pkg::slot_entry_t tick_entry,
    output ppnf_pkg::slot_entry_t spawn_entry
);

    logic [15:0]        life_new;
    logic               alive_new;
    logic signed [48:0] mx, my, mz;
    logic signed [48:0] sx, sy, sz;
    logic signed [16:0] dt_s, sc_s;

    assign dt_s = $signed({1'b0, step_dt});
    assign sc_s = $signed({1'b0, velocity_scale});

    assign life_new  = (cur.life > step_dt) ? cur.life - step_dt : 16'd0;
    assign alive_new = (life_new != 16'd0);

    // Products fit 32 bits after the floor shift.
    assign mx = cur.vx * dt_s;
    assign my = cur.vy * dt_s;
    assign mz = cur.vz * dt_s;

    always_comb begin
        tick_entry      = cur;
        tick_entry.life = life_new;
        if (alive_new) begin
            tick_entry.px = ppnf_pkg::sat33({cur.px[31], cur.px} - {mx[47], mx[47:16]});
            tick_entry.py = ppnf_pkg::sat33({cur.py[31], cur.py} - {my[47], my[47:16]});
            tick_entry.pz = ppnf_pkg::sat33({cur.pz[31], cur.pz} - {mz[47], mz[47:16]});
            tick_entry.alpha = (12'(cur.alpha) > fall) ? cur.alpha - 9'(fall) : 9'd0;
        end
    end

    assign sx = emit_vx * sc_s;
    assign sy = emit_vy * sc_s;
    assign sz = emit_vz * sc_s;

    always_comb begin
        spawn_entry.px     = ppnf_pkg::sat33({emit_x[31], emit_x} + {shift_x[31], shift_x});
        spawn_entry.py     = ppnf_pkg::sat33({emit_y[31], emit_y} + {shift_y[31], shift_y});
        spawn_entry.pz     = ppnf_pkg::sat33({emit_z[31], emit_z} + {shift_z[31], shift_z});
        spawn_entry.vx     = sx[47:16];
        spawn_entry.vy     = sy[47:16];
        spawn_entry.vz     = sz[47:16];
        spawn_entry.life   = initial_life;
        spawn_entry.bright = ppnf_pkg::bright_of(color_random);
        spawn_entry.alpha  = ppnf_pkg::Q_ONE;
    end

endmodule

FILE: design/particle_pool_next_fit_update.sv
// Particle pool with next-fit spawn and streaming tick update over a slot memory.
// One item is worked at a time and s_ready is high only while the block is idle.
// A tick reads one slot per cycle from the state memory's single read port and
// writes it back updated, so its POOL_SIZE results pass through the registered
// read and the output register and follow one per cycle while m_ready stays high.
// A spawn scans the pool one slot per cycle from the last used slot, then writes
// the chosen slot and presents one result once the scan stops, at a dead slot or
// at the end of the pool. Slot state comes out of reset without any clearing pass.
// Configuration writes take effect the next cycle.
module particle_pool_next_fit_update #(
    parameter int POOL_SIZE = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [ppnf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppnf_pkg::CFG_DAT_W-1:0] cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [15:0]        s_step_dt,
    input  logic signed [31:0] s_emit_x,
    input  logic signed [31:0] s_emit_y,
    input  logic signed [31:0] s_emit_z,
    input  logic signed [31:0] s_emit_vx,
    input  logic signed [31:0] s_emit_vy,
    input  logic signed [31:0] s_emit_vz,
    input  logic signed [31:0] s_shift_x,
    input  logic signed [31:0] s_shift_y,
    input  logic signed [31:0] s_shift_z,
    input  logic [6:0]         s_color_random,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_slot,
    output logic               m_alive,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic [8:0]         m_brightness,
    output logic [8:0]         m_opacity,
    output logic               m_last
);

    localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W = $clog2(POOL_SIZE + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

    // configuration
    logic [15:0] init_life_reg;
    logic [11:0] fade_rate_reg;
    logic [15:0] vel_scale_reg;

    // latched item
    logic               op_reg;
    logic [15:0]        dt_reg;
    logic [11:0]        fall_reg;
    logic signed [31:0] ex_reg, ey_reg, ez_reg;
    logic signed [31:0] evx_reg, evy_reg, evz_reg;
    logic signed [31:0] shx_reg, shy_reg, shz_reg;
    logic [6:0]         rnd_reg;
    logic [27:0]        fall_prod;

    // control
    ppnf_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] iss_idx_reg, iss_idx_next;
    logic [CNT_W-1:0] iss_cnt_reg, iss_cnt_next;
    logic             s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0] s1_idx_reg, s1_idx_next;
    logic             s1_last_reg, s1_last_next;
    logic [IDX_W-1:0] found_reg, found_next;
    logic [IDX_W-1:0] next_fit_reg, next_fit_next;

    logic in_xfer, out_free, adv, issue, hit, search_done, tick_fire, spawn_fire;
    logic in_search, in_tick, in_spawn;

    ppnf_pkg::slot_entry_t rd_entry, tick_entry, spawn_entry, wr_entry;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;

    // output register
    logic               m_valid_reg;
    logic [5:0]         m_slot_reg;
    logic               m_alive_reg, m_last_reg;
    logic signed [31:0] m_x_reg, m_y_reg, m_z_reg;
    logic [8:0]         m_bright_reg, m_alpha_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_life_reg <= ppnf_pkg::INIT_LIFE_RST;
            fade_rate_reg <= ppnf_pkg::FADE_RATE_RST;
            vel_scale_reg <= ppnf_pkg::VEL_SCALE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ppnf_pkg::REG_INIT_LIFE: init_life_reg <= cfg_wdata;
                ppnf_pkg::REG_FADE_RATE: fade_rate_reg <= cfg_wdata[11:0];
                ppnf_pkg::REG_VEL_SCALE: vel_scale_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_xfer   = s_valid && s_ready;
    assign fall_prod = 28'(fade_rate_reg) * 28'(s_step_dt);

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            op_reg   <= s_opcode;
            dt_reg   <= s_step_dt;
            fall_reg <= fall_prod[27:16];
            ex_reg   <= s_emit_x;
            ey_reg   <= s_emit_y;
            ez_reg   <= s_emit_z;
            evx_reg  <= s_emit_vx;
            evy_reg  <= s_emit_vy;
            evz_reg  <= s_emit_vz;
            shx_reg  <= s_shift_x;
            shy_reg  <= s_shift_y;
            shz_reg  <= s_shift_z;
            rnd_reg  <= s_color_random;
        end
    end

    // Controller outputs.
    always_comb begin
        s_ready   = 1'b0;
        in_search = 1'b0;
        in_tick   = 1'b0;
        in_spawn  = 1'b0;
        case (state_reg)
            ppnf_pkg::ST_IDLE:   s_ready   = 1'b1;
            ppnf_pkg::ST_SEARCH: in_search = 1'b1;
            ppnf_pkg::ST_SPAWN:  in_spawn  = 1'b1;
            ppnf_pkg::ST_TICK:   in_tick   = 1'b1;
            default: ;
        endcase
    end

    assign out_free    = !m_valid_reg || m_ready;
    // The scan never stalls; the tick holds its read stage while the output is full.
    assign adv         = in_search || !s1_valid_reg || out_free;
    assign issue       = (in_search || in_tick) && adv && (iss_cnt_reg < CNT_W'(POOL_SIZE));
    assign hit         = s1_valid_reg && (rd_entry.life == 16'd0);
    assign search_done = in_search && s1_valid_reg && (hit || s1_last_reg);
    assign tick_fire   = in_tick && s1_valid_reg && out_free;
    assign spawn_fire  = in_spawn && out_free;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ppnf_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = (s_opcode == ppnf_pkg::OP_TICK) ? ppnf_pkg::ST_TICK
                                                                 : ppnf_pkg::ST_SEARCH;
                end
            end
            ppnf_pkg::ST_SEARCH: if (search_done) state_next = ppnf_pkg::ST_SPAWN;
            ppnf_pkg::ST_SPAWN:  if (spawn_fire) state_next = ppnf_pkg::ST_IDLE;
            ppnf_pkg::ST_TICK:   if (tick_fire && s1_last_reg) state_next = ppnf_pkg::ST_IDLE;
            default:             state_next = ppnf_pkg::ST_IDLE;
        endcase
    end

    // Read pipeline and slot choice.
    always_comb begin
        iss_idx_next  = iss_idx_reg;
        iss_cnt_next  = iss_cnt_reg;
        s1_valid_next = s1_valid_reg;
        s1_idx_next   = s1_idx_reg;
        s1_last_next  = s1_last_reg;
        found_next    = found_reg;
        next_fit_next = next_fit_reg;
        if (in_xfer) begin
            iss_idx_next  = (s_opcode == ppnf_pkg::OP_TICK) ? '0 : next_fit_reg;
            iss_cnt_next  = '0;
            s1_valid_next = 1'b0;
        end else if (adv) begin
            s1_valid_next = issue;
            if (issue) begin
                s1_idx_next  = iss_idx_reg;
                s1_last_next = (iss_cnt_reg == CNT_W'(POOL_SIZE - 1));
                iss_cnt_next = iss_cnt_reg + 1'b1;
                iss_idx_next = (iss_idx_reg == LAST_IDX) ? '0 : iss_idx_reg + 1'b1;
            end
        end
        // With no dead slot, take slot 0.
        if (search_done) begin
            found_next    = hit ? s1_idx_reg : '0;
            next_fit_next = hit ? s1_idx_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ppnf_pkg::ST_IDLE;
            iss_idx_reg  <= '0;
            iss_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_idx_reg   <= '0;
            s1_last_reg  <= 1'b0;
            found_reg    <= '0;
            next_fit_reg <= '0;
        end else begin
            state_reg    <= state_next;
            iss_idx_reg  <= iss_idx_next;
            iss_cnt_reg  <= iss_cnt_next;
            s1_valid_reg <= s1_valid_next;
            s1_idx_reg   <= s1_idx_next;
            s1_last_reg  <= s1_last_next;
            found_reg    <= found_next;
            next_fit_reg <= next_fit_next;
        end
    end

    // Tick reads and writes distinct slots; the scan only reads, so no forwarding.
    assign wr_en    = tick_fire || spawn_fire;
    assign wr_addr  = in_tick ? s1_idx_reg : found_reg;
    assign wr_entry = in_tick ? tick_entry : spawn_entry;

    ppnf_pool_mem #(
        .DEPTH (POOL_SIZE),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (issue),
        .rd_addr (iss_idx_reg),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry)
    );

    ppnf_slot_calc u_calc (
        .cur            (rd_entry),
        .step_dt        (dt_reg),
        .fall           (fall_reg),
        .emit_x         (ex_reg),
        .emit_y         (ey_reg),
        .emit_z         (ez_reg),
        .emit_vx        (evx_reg),
        .emit_vy        (evy_reg),
        .emit_vz        (evz_reg),
        .shift_x        (shx_reg),
        .shift_y        (shy_reg),
        .shift_z        (shz_reg),
        .color_random   (rnd_reg),
        .initial_life   (init_life_reg),
        .velocity_scale (vel_scale_reg),
        .tick_entry     (tick_entry),
        .spawn_entry    (spawn_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (wr_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            m_slot_reg   <= 6'(wr_addr);
            m_alive_reg  <= (wr_entry.life != 16'd0);
            m_x_reg      <= wr_entry.px;
            m_y_reg      <= wr_entry.py;
            m_z_reg      <= wr_entry.pz;
            m_bright_reg <= wr_entry.bright;
            m_alpha_reg  <= wr_entry.alpha;
            m_last_reg   <= in_tick ? s1_last_reg : 1'b1;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_slot       = m_slot_reg;
    assign m_alive      = m_alive_reg;
    assign m_out_x      = m_x_reg;
    assign m_out_y      = m_y_reg;
    assign m_out_z      = m_z_reg;
    assign m_brightness = m_bright_reg;
    assign m_opacity    = m_alpha_reg;
    assign m_last       = m_last_reg;

    a_tick_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && s_opcode == ppnf_pkg::OP_TICK |=>
            state_reg == ppnf_pkg::ST_TICK && iss_idx_reg == '0 && iss_cnt_reg == '0)
        else $error("tick does not start at slot 0");

    a_tick_order: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_fire && s1_last_reg |-> s1_idx_reg == LAST_IDX)
        else $error("final tick result is not the last slot");

    a_spawn_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        spawn_fire |=> m_slot == 6'(next_fit_reg) && m_last && op_reg == ppnf_pkg::OP_SPAWN)
        else $error("spawn result does not match the next-fit slot");

endmodule

FILE: tb/particle_pool_checker.sv
// Checker for the particle pool: tracks the pool from observed transfers and compares results.
`timescale 1ns / 1ps

module particle_pool_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ppnf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppnf_pkg::CFG_DAT_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_opcode,
    input  logic [15:0]                    s_step_dt,
    input  logic signed [31:0]             s_emit_x,
    input  logic signed [31:0]             s_emit_y,
    input  logic signed [31:0]             s_emit_z,
    input  logic signed [31:0]             s_emit_vx,
    input  logic signed [31:0]             s_emit_vy,
    input  logic signed [31:0]             s_emit_vz,
    input  logic signed [31:0]             s_shift_x,
    input  logic signed [31:0]             s_shift_y,
    input  logic signed [31:0]             s_shift_z,
    input  logic [6:0]                     s_color_random,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [5:0]                     m_slot,
    input  logic                           m_alive,
    input  logic signed [31:0]             m_out_x,
    input  logic signed [31:0]             m_out_y,
    input  logic signed [31:0]             m_out_z,
    input  logic [8:0]                     m_brightness,
    input  logic [8:0]                     m_opacity,
    input  logic                           m_last,
    output int                             n_waiting,
    output int                             n_errors,
    output int                             n_reports
);

    localparam int N_SLOTS = 64;

    typedef struct packed {
        logic [5:0]         slot;
        logic               alive;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [8:0]         bright;
        logic [8:0]         alpha;
        logic               last;
    } slot_report_t;

    logic signed [31:0] pos_x [N_SLOTS];
    logic signed [31:0] pos_y [N_SLOTS];
    logic signed [31:0] pos_z [N_SLOTS];
    logic signed [31:0] vel_x [N_SLOTS];
    logic signed [31:0] vel_y [N_SLOTS];
    logic signed [31:0] vel_z [N_SLOTS];
    logic [15:0]        life_left [N_SLOTS];
    logic [8:0]         grey [N_SLOTS];
    logic [8:0]         alpha [N_SLOTS];
    logic [5:0]         search_from;

    logic [15:0] life_init;
    logic [11:0] fade_per_sec;
    logic [15:0] vel_gain;

    slot_report_t report_q[$];
    int           err_count = 0;
    int           report_count = 0;

    assign n_errors  = err_count;
    assign n_reports = report_count;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Arithmetic shift of a signed product rounds toward minus infinity.
    function automatic longint q16_floor(input longint p);
        return p >>> 16;
    endfunction

    function automatic slot_report_t report_of(input int s, input logic is_last);
        slot_report_t r;
        r.slot   = s[5:0];
        r.alive  = (life_left[s] != 16'd0);
        r.x      = pos_x[s];
        r.y      = pos_y[s];
        r.z      = pos_z[s];
        r.bright = grey[s];
        r.alpha  = alpha[s];
        r.last   = is_last;
        return r;
    endfunction

    // Append one expected result at the tail of the queue.
    task automatic enqueue_report(input slot_report_t r);
        report_q.insert(report_q.size(), r);
    endtask

    task automatic clear_pool();
        for (int i = 0; i < N_SLOTS; i++) begin
            pos_x[i] = '0; pos_y[i] = '0; pos_z[i] = '0;
            vel_x[i] = '0; vel_y[i] = '0; vel_z[i] = '0;
            life_left[i] = '0;
            grey[i]      = 9'd256;
            alpha[i]     = 9'd256;
        end
        search_from  = '0;
        life_init    = ppnf_pkg::INIT_LIFE_RST;
        fade_per_sec = ppnf_pkg::FADE_RATE_RST;
        vel_gain     = ppnf_pkg::VEL_SCALE_RST;
    endtask

    task automatic spawn_particle();
        int     idx;
        int     s;
        int     rc;
        logic   found;
        longint gain;
        s     = 0;
        found = 1'b0;
        // next-fit: first dead slot at or after the last one used, wrapping
        for (int k = 0; k < N_SLOTS; k++) begin
            idx = (int'(search_from) + k) % N_SLOTS;
            if (!found && life_left[idx] == 16'd0) begin
                s     = idx;
                found = 1'b1;
            end
        end
        search_from = found ? s[5:0] : 6'd0;
        gain = longint'(vel_gain);
        rc   = (s_color_random > 7'd99) ? 99 : int'(s_color_random);
        pos_x[s] = clamp32(longint'(s_emit_x) + longint'(s_shift_x));
        pos_y[s] = clamp32(longint'(s_emit_y) + longint'(s_shift_y));
        pos_z[s] = clamp32(longint'(s_emit_z) + longint'(s_shift_z));
        vel_x[s] = clamp32(q16_floor(longint'(s_emit_vx) * gain));
        vel_y[s] = clamp32(q16_floor(longint'(s_emit_vy) * gain));
        vel_z[s] = clamp32(q16_floor(longint'(s_emit_vz) * gain));
        life_left[s] = life_init;
        grey[s]      = 9'(128 + rc * 256 / 100);
        alpha[s]     = 9'd256;
        enqueue_report(report_of(s, 1'b1));
    endtask

    task automatic advance_pool(input logic [15:0] dt);
        longint dtl;
        longint fall;
        dtl  = longint'(dt);
        fall = (longint'(fade_per_sec) * dtl) >>> 16;
        for (int i = 0; i < N_SLOTS; i++) begin
            life_left[i] = (life_left[i] > dt) ? life_left[i] - dt : 16'd0;
            // dead slots keep position and alpha
            if (life_left[i] != 16'd0) begin
                pos_x[i] = clamp32(longint'(pos_x[i]) - q16_floor(longint'(vel_x[i]) * dtl));
                pos_y[i] = clamp32(longint'(pos_y[i]) - q16_floor(longint'(vel_y[i]) * dtl));
                pos_z[i] = clamp32(longint'(pos_z[i]) - q16_floor(longint'(vel_z[i]) * dtl));
                alpha[i] = (longint'(alpha[i]) > fall) ? 9'(longint'(alpha[i]) - fall) : 9'd0;
            end
            enqueue_report(report_of(i, i == N_SLOTS - 1));
        end
    endtask

    task automatic check_field(input string what, input logic [5:0] slot,
                               input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: slot %0d %s mismatch: expected %h actual %h",
                     $time, slot, what, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        slot_report_t got;
        slot_report_t want;
        if (!aresetn) begin
            clear_pool();
            report_q.delete();
            n_waiting <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_slot, m_alive, m_out_x, m_out_y, m_out_z,
                        m_brightness, m_opacity, m_last};
                report_count++;
                if (report_q.size() == 0) begin
                    $display("%0t: result transfer for slot %0d with nothing expected",
                             $time, m_slot);
                    err_count++;
                end else begin
                    want = report_q.pop_front();
                    check_field("slot",       want.slot, 32'(want.slot),   32'(got.slot));
                    check_field("alive",      want.slot, 32'(want.alive),  32'(got.alive));
                    check_field("out_x",      want.slot, want.x,           got.x);
                    check_field("out_y",      want.slot, want.y,           got.y);
                    check_field("out_z",      want.slot, want.z,           got.z);
                    check_field("brightness", want.slot, 32'(want.bright), 32'(got.bright));
                    check_field("opacity",    want.slot, 32'(want.alpha),  32'(got.alpha));
                    check_field("last",       want.slot, 32'(want.last),   32'(got.last));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    ppnf_pkg::REG_INIT_LIFE: life_init    = cfg_wdata;
                    ppnf_pkg::REG_FADE_RATE: fade_per_sec = cfg_wdata[11:0];
                    ppnf_pkg::REG_VEL_SCALE: vel_gain     = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_opcode == ppnf_pkg::OP_SPAWN) begin
                    spawn_particle();
                end else begin
                    advance_pool(s_step_dt);
                end
            end
            n_waiting <= report_q.size();
        end
    end

endmodule

FILE: tb/particle_pool_next_fit_update_test.sv
// Top of the particle pool testbench: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 1ps

module particle_pool_next_fit_update_test;

    localparam int CYCLE_LIMIT = 5_000_000;
    // index past the last register, must be ignored
    localparam logic [ppnf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        dt;
        logic signed [31:0] ex, ey, ez;
        logic signed [31:0] vx, vy, vz;
        logic signed [31:0] dx, dy, dz;
        logic [6:0]         rnd;
    } pool_cmd_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                           cfg_wr_en = 1'b0;
    logic [ppnf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ppnf_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_opcode = 1'b0;
    logic [15:0]        s_step_dt = '0;
    logic signed [31:0] s_emit_x = '0, s_emit_y = '0, s_emit_z = '0;
    logic signed [31:0] s_emit_vx = '0, s_emit_vy = '0, s_emit_vz = '0;
    logic signed [31:0] s_shift_x = '0, s_shift_y = '0, s_shift_z = '0;
    logic [6:0]         s_color_random = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [5:0]         m_slot;
    logic               m_alive;
    logic signed [31:0] m_out_x, m_out_y, m_out_z;
    logic [8:0]         m_brightness;
    logic [8:0]         m_opacity;
    logic               m_last;

    int n_waiting;
    int n_errors;
    int n_reports;

    int   cycle_count = 0;
    int   ready_hold  = 0;
    logic calm        = 1'b0;
    int   n_spawns    = 0;
    int   n_ticks     = 0;
    int   n_settings  = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    particle_pool_next_fit_update #(.POOL_SIZE(64)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode), .s_step_dt(s_step_dt),
        .s_emit_x(s_emit_x), .s_emit_y(s_emit_y), .s_emit_z(s_emit_z),
        .s_emit_vx(s_emit_vx), .s_emit_vy(s_emit_vy), .s_emit_vz(s_emit_vz),
        .s_shift_x(s_shift_x), .s_shift_y(s_shift_y), .s_shift_z(s_shift_z),
        .s_color_random(s_color_random),
        .m_valid(m_valid), .m_ready(m_ready), .m_slot(m_slot), .m_alive(m_alive),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z),
        .m_brightness(m_brightness), .m_opacity(m_opacity), .m_last(m_last)
    );

    particle_pool_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode), .s_step_dt(s_step_dt),
        .s_emit_x(s_emit_x), .s_emit_y(s_emit_y), .s_emit_z(s_emit_z),
        .s_emit_vx(s_emit_vx), .s_emit_vy(s_emit_vy), .s_emit_vz(s_emit_vz),
        .s_shift_x(s_shift_x), .s_shift_y(s_shift_y), .s_shift_z(s_shift_z),
        .s_color_random(s_color_random),
        .m_valid(m_valid), .m_ready(m_ready), .m_slot(m_slot), .m_alive(m_alive),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z),
        .m_brightness(m_brightness), .m_opacity(m_opacity), .m_last(m_last),
        .n_waiting(n_waiting), .n_errors(n_errors), .n_reports(n_reports)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, n_waiting);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones; none while calm is set.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm) return 0;
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Result side: alternate runs of ready with random stalls.
    always @(posedge aclk) begin
        int stall;
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_ready) begin
            stall = pick_gap();
            if (stall > 0) begin
                m_ready    <= 1'b0;
                ready_hold <= stall - 1;
            end else begin
                ready_hold <= $urandom_range(0, 15);
            end
        end else begin
            m_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 15);
        end
    end

    function automatic logic signed [31:0] any_q16();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
            default: return $urandom;
        endcase
    endfunction

    function automatic pool_cmd_t spawn_cmd(
        input logic signed [31:0] ex, ey, ez, vx, vy, vz, dx, dy, dz,
        input logic [6:0] rnd);
        pool_cmd_t c;
        c = '{ppnf_pkg::OP_SPAWN, 16'($urandom), ex, ey, ez, vx, vy, vz, dx, dy, dz, rnd};
        return c;
    endfunction

    function automatic pool_cmd_t tick_cmd(input logic [15:0] dt);
        pool_cmd_t c;
        c = '{ppnf_pkg::OP_TICK, dt, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, 7'($urandom)};
        return c;
    endfunction

    function automatic pool_cmd_t random_cmd(input int tick_pct, input int big_pct);
        logic [15:0] dt;
        logic [6:0]  rnd;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)           dt = 16'd0;
        else if (roll < big_pct + 10) dt = 16'($urandom);
        else                     dt = 16'($urandom_range(1, 3000));
        rnd = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 99))
                                           : 7'($urandom_range(100, 127));
        if ($urandom_range(0, 99) < tick_pct) return tick_cmd(dt);
        return spawn_cmd(any_q16(), any_q16(), any_q16(), any_q16(), any_q16(),
                         any_q16(), any_q16(), any_q16(), any_q16(), rnd);
    endfunction

    task automatic send_cmd(input pool_cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_opcode       <= c.opcode;
        s_step_dt      <= c.dt;
        s_emit_x       <= c.ex;
        s_emit_y       <= c.ey;
        s_emit_z       <= c.ez;
        s_emit_vx      <= c.vx;
        s_emit_vy      <= c.vy;
        s_emit_vz      <= c.vz;
        s_shift_x      <= c.dx;
        s_shift_y      <= c.dy;
        s_shift_z      <= c.dz;
        s_color_random <= c.rnd;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (c.opcode == ppnf_pkg::OP_SPAWN) n_spawns++;
        else n_ticks++;
    endtask

    // Hold the sender until every expected result has been transferred.
    task automatic wait_all_reported();
        s_valid <= 1'b0;
        do @(posedge aclk); while (n_waiting != 0);
    endtask

    task automatic set_reg(input logic [ppnf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ppnf_pkg::CFG_DAT_W-1:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [15:0] life, input logic [15:0] fade,
                                 input logic [15:0] gain);
        wait_all_reported();
        set_reg(ppnf_pkg::REG_INIT_LIFE, life);
        set_reg(ppnf_pkg::REG_FADE_RATE, fade);
        set_reg(ppnf_pkg::REG_VEL_SCALE, gain);
        n_settings++;
    endtask

    task automatic run_phase(input int n_items, input int tick_pct, input int big_pct,
                             input int calm_items);
        for (int i = 0; i < n_items; i++) begin
            calm = (i < calm_items);
            if ($urandom_range(0, 99) < 4) wait_all_reported();
            send_cmd(random_cmd(tick_pct, big_pct));
        end
        calm = 1'b0;
    endtask

    localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMIN = 32'sh8000_0000;

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        n_settings = 1;

        // directed: reset settings, empty pool, saturating spawns, color clamp
        send_cmd(tick_cmd(16'd0));
        send_cmd(spawn_cmd(QMAX, 32'sd0, -32'sd65536, QMAX, QMIN, -32'sd1,
                           QMAX, 32'sd0, -32'sd1, 7'd0));
        send_cmd(spawn_cmd(QMIN, 32'sd0, 32'sd65536, QMIN, QMAX, 32'sd1,
                           QMIN, -32'sd1, 32'sd1, 7'd99));
        send_cmd(spawn_cmd(32'sd1000, -32'sd1000, 32'sd0, 32'sd65536, -32'sd65536,
                           32'sd3, 32'sd5, -32'sd5, 32'sd0, 7'd100));
        send_cmd(spawn_cmd(-32'sd7, 32'sd7, QMAX, -32'sd3, 32'sd3, QMIN,
                           QMIN, QMAX, QMIN, 7'd127));
        send_cmd(tick_cmd(16'd1));
        send_cmd(tick_cmd(16'd19000));
        send_cmd(tick_cmd(16'hFFFF));
        send_cmd(spawn_cmd(32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6,
                           32'sd7, 32'sd8, 32'sd9, 7'd50));

        // largest settings; fade written with bits above its width
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(spawn_cmd(QMAX, QMIN, 32'sd0, QMIN, QMAX, QMIN,
                           32'sd0, 32'sd0, 32'sd0, 7'd1));
        send_cmd(spawn_cmd(QMIN, QMAX, 32'sd0, QMAX, QMIN, QMAX,
                           32'sd0, 32'sd0, 32'sd0, 7'd98));
        send_cmd(spawn_cmd(32'sd0, 32'sd0, 32'sd0, -32'sd1, 32'sd1, 32'sd65535,
                           32'sd0, 32'sd0, 32'sd0, 7'd64));
        send_cmd(tick_cmd(16'd40000));
        send_cmd(tick_cmd(16'hFFFF));

        // smallest settings, plus a write to an index with no register
        load_settings(16'd0, 16'd0, 16'd0);
        set_reg(REG_UNUSED, 16'hFFFF);
        send_cmd(spawn_cmd(32'sd100, 32'sd200, 32'sd300, QMAX, QMIN, QMAX,
                           32'sd1, 32'sd2, 32'sd3, 7'd33));
        send_cmd(tick_cmd(16'd500));

        // random: a spawn-heavy phase that fills the pool, then mixed phases
        load_settings(16'hFFFF, 16'h0FFF, 16'hFFFF);
        run_phase(90, 5, 0, 0);
        load_settings(16'd0, 16'd0, 16'd0);
        run_phase(30, 30, 10, 0);
        load_settings(16'($urandom), 16'($urandom), 16'($urandom));
        run_phase(70, 25, 15, 0);
        load_settings(16'($urandom_range(20000, 65535)), 16'($urandom), 16'($urandom));
        run_phase(70, 20, 10, 35);
        load_settings(16'($urandom), 16'($urandom), 16'($urandom));
        run_phase(70, 35, 20, 0);

        wait_all_reported();
        repeat (8) @(posedge aclk);

        $display("Ran %0d spawns and %0d ticks under %0d register settings,",
                 n_spawns, n_ticks, n_settings);
        $display("with %0d slot results compared and random stalls on both sides.",
                 n_reports);
        if (n_errors == 0 && n_waiting == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
